// ----- design/bia_pkg.sv -----
`timescale 1ns / 1ps

package bia_pkg;

    // Identifier space and map geometry. WORD_BITS is a power of two.
    localparam int MAX_ID    = 65535;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (MAX_ID + WORD_BITS) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CNT_W     = $clog2(MAP_WORDS + 1);

    // Fixed field widths
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int ID_W = 16;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_ONES = '1;
    localparam word_t WORD_ONE  = word_t'(1);
    // Bits of the last word that stand for identifiers up to MAX_ID
    localparam word_t LAST_MASK = WORD_ONES >> (WORD_BITS - 1 - (MAX_ID % WORD_BITS));
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAX_ID / WORD_BITS);
    localparam logic [ID_W-1:0]   MAX_ID_V  = ID_W'(MAX_ID);
    localparam logic [CNT_W-1:0]  SCAN_LAST = CNT_W'(MAP_WORDS);

    // Command codes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_INIT  = 2'd2;
    localparam logic [OP_W-1:0] OP_EXIT  = 2'd3;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic clr_wr;
        logic acc_alloc;
        logic acc_free;
        logic scan_step;
        logic alloc_ok;
        logic free_ok;
        logic fail_nospace;
        logic fail_invalid;
        logic do_init;
        logic do_exit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic disabled;
        logic fid_bad;
        logic hit;
        logic scan_done;
        logic bit_set;
        logic clr_last;
    } dp_stat_t;

endpackage

// ----- design/bia_ctrl.sv -----
`timescale 1ns / 1ps

module bia_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bia_pkg::OP_W-1:0]  opcode,
    input  bia_pkg::dp_stat_t         stat,
    output logic                      busy,
    output bia_pkg::dp_cmd_t          cmd
);
    import bia_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (opcode)
                        OP_ALLOC:
                        begin
                            if (stat.disabled)
                            begin
                                cmd.fail_nospace = 1'b1;
                            end
                            else
                            begin
                                cmd.acc_alloc = 1'b1;
                                state_next    = S_SCAN;
                            end
                        end
                        OP_FREE:
                        begin
                            if (stat.disabled || stat.fid_bad)
                            begin
                                cmd.fail_invalid = 1'b1;
                            end
                            else
                            begin
                                cmd.acc_free = 1'b1;
                                state_next   = S_FREE;
                            end
                        end
                        OP_INIT:
                        begin
                            cmd.do_init = 1'b1;
                            if (stat.disabled)
                            begin
                                state_next = S_CLEAR;
                            end
                        end
                        OP_EXIT:
                        begin
                            cmd.do_exit = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (stat.hit)
                begin
                    cmd.alloc_ok = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.scan_done)
                begin
                    cmd.fail_nospace = 1'b1;
                    state_next       = S_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FREE:
            begin
                if (stat.bit_set)
                begin
                    cmd.free_ok = 1'b1;
                end
                else
                begin
                    cmd.fail_invalid = 1'b1;
                end
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/bia_datapath.sv -----
`timescale 1ns / 1ps

module bia_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bia_pkg::dp_cmd_t          cmd,
    input  logic [bia_pkg::ID_W-1:0]  free_id,
    output bia_pkg::dp_stat_t         stat,
    output logic                      done,
    output logic [bia_pkg::ST_W-1:0]  status,
    output logic [bia_pkg::ID_W-1:0]  granted_id,
    output logic [bia_pkg::ID_W-1:0]  live_count
);
    import bia_pkg::*;

    function automatic logic [BIT_W-1:0] low_index(input word_t v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    word_t map_mem [MAP_WORDS];
    word_t rd_data_reg;

    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] cur_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ID_W-1:0]   fid_reg;
    logic [ID_W-1:0]   search_reg;
    logic [ID_W-1:0]   search_next;
    logic [ID_W-1:0]   used_reg;
    logic [ID_W-1:0]   used_next;
    logic              disabled_reg;
    logic              disabled_next;

    logic              done_reg;
    logic [ST_W-1:0]   status_reg;
    logic [ID_W-1:0]   granted_reg;
    logic [ID_W-1:0]   count_reg;

    logic [ADDR_W-1:0] start_word;
    logic [BIT_W-1:0]  start_bit;
    logic [ADDR_W-1:0] in_word;
    logic [ADDR_W-1:0] fid_word;
    logic [BIT_W-1:0]  fid_bit;
    logic [ADDR_W-1:0] cur_inc;
    logic [BIT_W-1:0]  hit_bit;
    logic [ID_W-1:0]   hit_id;
    logic [ID_W-1:0]   search_after_alloc;
    word_t             range_mask;
    word_t             phase_mask;
    word_t             hi_mask;
    word_t             free_bits;
    word_t             wr_data;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic              rd_en;

    assign start_word = search_reg[BIT_W +: ADDR_W];
    assign start_bit  = search_reg[BIT_W-1:0];
    assign in_word    = free_id[BIT_W +: ADDR_W];
    assign fid_word   = fid_reg[BIT_W +: ADDR_W];
    assign fid_bit    = fid_reg[BIT_W-1:0];
    assign cur_inc    = (cur_reg == LAST_WORD) ? '0 : cur_reg + 1'b1;

    // Candidate bits of the word under scan: drop id 0 and ids past the top,
    // and split the start word into its upper part (first visit) and its
    // lower part (last visit, after the wrap).
    assign hi_mask = WORD_ONES << start_bit;

    always_comb
    begin
        range_mask = WORD_ONES;
        if (cur_reg == '0)
        begin
            range_mask[0] = 1'b0;
        end
        if (cur_reg == LAST_WORD)
        begin
            range_mask = range_mask & LAST_MASK;
        end
    end

    always_comb
    begin
        priority if (cnt_reg == '0)
        begin
            phase_mask = hi_mask;
        end
        else if (cnt_reg == SCAN_LAST)
        begin
            phase_mask = ~hi_mask;
        end
        else
        begin
            phase_mask = WORD_ONES;
        end
    end

    assign free_bits = ~rd_data_reg & range_mask & phase_mask;
    assign hit_bit   = low_index(free_bits);
    assign hit_id    = ID_W'({cur_reg, hit_bit});
    assign search_after_alloc = (hit_id == MAX_ID_V) ? ID_W'(1) : hit_id + 1'b1;

    assign stat.disabled  = disabled_reg;
    assign stat.fid_bad   = (free_id == '0) || (free_id > MAX_ID_V);
    assign stat.hit       = |free_bits;
    assign stat.scan_done = (cnt_reg == SCAN_LAST);
    assign stat.bit_set   = rd_data_reg[fid_bit];
    assign stat.clr_last  = (clr_reg == LAST_WORD);

    // Map RAM: one write port, one registered read port
    assign wr_en = cmd.clr_wr | cmd.alloc_ok | cmd.free_ok;
    assign rd_en = cmd.acc_alloc | cmd.acc_free | cmd.scan_step;

    always_comb
    begin
        priority if (cmd.clr_wr)
        begin
            wr_addr = clr_reg;
            wr_data = (clr_reg == '0) ? WORD_ONE : '0;
        end
        else if (cmd.alloc_ok)
        begin
            wr_addr = cur_reg;
            wr_data = rd_data_reg | (WORD_ONE << hit_bit);
        end
        else
        begin
            wr_addr = fid_word;
            wr_data = rd_data_reg & ~(WORD_ONE << fid_bit);
        end
    end

    always_comb
    begin
        priority if (cmd.acc_alloc)
        begin
            rd_addr = start_word;
        end
        else if (cmd.acc_free)
        begin
            rd_addr = in_word;
        end
        else
        begin
            rd_addr = cur_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // Allocator state
    always_comb
    begin
        used_next     = used_reg;
        search_next   = search_reg;
        disabled_next = disabled_reg;
        priority if (cmd.do_exit)
        begin
            used_next     = '0;
            search_next   = ID_W'(1);
            disabled_next = 1'b1;
        end
        else if (cmd.do_init && disabled_reg)
        begin
            used_next     = '0;
            search_next   = ID_W'(1);
            disabled_next = 1'b0;
        end
        else if (cmd.alloc_ok)
        begin
            used_next   = used_reg + 1'b1;
            search_next = search_after_alloc;
        end
        else if (cmd.free_ok)
        begin
            used_next = used_reg - 1'b1;
            if (fid_reg < search_reg)
            begin
                search_next = fid_reg;
            end
        end
        else
        begin
            used_next = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            cur_reg      <= '0;
            cnt_reg      <= '0;
            used_reg     <= '0;
            search_reg   <= ID_W'(1);
            disabled_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= (clr_reg == LAST_WORD) ? '0 : clr_reg + 1'b1;
            end
            if (cmd.acc_alloc)
            begin
                cur_reg <= start_word;
                cnt_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                cur_reg <= cur_inc;
                cnt_reg <= cnt_reg + 1'b1;
            end
            used_reg     <= used_next;
            search_reg   <= search_next;
            disabled_reg <= disabled_next;
            done_reg     <= cmd.alloc_ok | cmd.free_ok | cmd.fail_nospace
                          | cmd.fail_invalid | cmd.do_init | cmd.do_exit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_free)
        begin
            fid_reg <= free_id;
        end
        priority if (cmd.fail_nospace)
        begin
            status_reg <= ST_NOSPACE;
        end
        else if (cmd.fail_invalid)
        begin
            status_reg <= ST_INVALID;
        end
        else
        begin
            status_reg <= ST_OK;
        end
        granted_reg <= cmd.alloc_ok ? hit_id : '0;
        count_reg   <= used_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = granted_reg;
    assign live_count = count_reg;

endmodule

// ----- design/bitmap_id_allocator.sv -----
`timescale 1ns / 1ps

// Channel   Handshake            Word
// --------  -------------------  ----------------------------------------
// command   start in, busy out   opcode[1:0], free_id[15:0]
// result    done out (strobe)    status[1:0], granted_id[15:0], live_count[15:0]
//
// A command word is taken on a rising edge with start high and busy low.
// Init, exit, and a command refused at decode (allocate or free while disabled,
// free of identifier 0) report in the next cycle; any other free reports after
// one read-modify-write of its map word. Allocate reports after scanning the
// start word and k map words past it (k from 0 to MAP_WORDS): the map RAM's
// single read port delivers one word per cycle. After reset, and after an init
// that wakes a disabled block, busy holds high for a pass that clears the map.
// done is high for one cycle per result; the receiver cannot stall it.

module bitmap_id_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [bia_pkg::OP_W-1:0]  opcode,
    input  logic [bia_pkg::ID_W-1:0]  free_id,
    output logic                      done,
    output logic [bia_pkg::ST_W-1:0]  status,
    output logic [bia_pkg::ID_W-1:0]  granted_id,
    output logic [bia_pkg::ID_W-1:0]  live_count
);
    import bia_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer: clearing pass, command decode, scan loop, free check
    bia_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Map RAM, hint, count, enable flag and result registers
    bia_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .free_id    (free_id),
        .stat       (stat),
        .done       (done),
        .status     (status),
        .granted_id (granted_id),
        .live_count (live_count)
    );

    // An accepted word either reports next cycle or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done || busy)
        else $error("accepted command neither reported nor kept busy");

    // A claimed bit shows up as a granted, nonzero identifier.
    a_grant_reported: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_ok |=> done && status == ST_OK && granted_id != '0)
        else $error("allocation commit not reported as a grant");

    // Failed commands never carry an identifier.
    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> granted_id == '0)
        else $error("failed result carries an identifier");

    // Allocate while disabled is refused at once.
    a_disabled_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && stat.disabled && opcode == OP_ALLOC
        |=> done && status == ST_NOSPACE)
        else $error("allocate while disabled not refused");

endmodule
